>>> design/afd_pkg.sv
// Shared types, constants and a helper function of the aspect-fit downscaler.
package afd_pkg;

  localparam int unsigned MaxDim  = 8192;
  localparam int unsigned DimW    = 14;
  localparam int unsigned CntW    = 13;
  localparam int unsigned PixW    = 32;
  localparam int unsigned ProdW   = 2 * DimW;
  localparam int unsigned CfgIdxW = 4;
  localparam int unsigned StepW   = $clog2(ProdW);

  localparam logic [CfgIdxW-1:0] RegSrcW = CfgIdxW'(0);
  localparam logic [CfgIdxW-1:0] RegSrcH = CfgIdxW'(1);
  localparam logic [CfgIdxW-1:0] RegMaxW = CfgIdxW'(2);
  localparam logic [CfgIdxW-1:0] RegMaxH = CfgIdxW'(3);

  typedef enum logic [1:0] {
    DIV_FIT,
    DIV_COL,
    DIV_ROW
  } div_sel_e;

  typedef enum logic [3:0] {
    ST_RUN,
    ST_LATCH,
    ST_MUL,
    ST_FIT,
    ST_FIT_WAIT,
    ST_COL,
    ST_COL_WAIT,
    ST_ROW,
    ST_ROW_WAIT,
    ST_FIRST
  } state_e;

  typedef struct packed {
    logic     latch;
    logic     mul;
    logic     fit;
    logic     div_start;
    div_sel_e div_sel;
    logic     store_fit;
    logic     store_col;
    logic     store_row;
    logic     accept;
  } cmd_t;

  typedef struct packed {
    logic frame_start;
    logic out_free;
    logic need_div;
    logic div_done;
    logic div_busy;
  } status_t;

  function automatic logic [DimW-1:0] clamp_dim(input logic [DimW-1:0] v);
    logic [DimW-1:0] r;
    r = v;
    if (v == '0) begin
      r = DimW'(1);
    end else if (v > DimW'(MaxDim)) begin
      r = DimW'(MaxDim);
    end
    return r;
  endfunction

endpackage

>>> design/aspect_fit_nearest_downscaler.sv
// Top level of the aspect-fit nearest-neighbour downscaler.
// Source pixels enter one word per accepted handshake on in_valid_i/in_ready_o in raster
// order; selected pixels leave on out_valid_o/out_ready_i with row and frame end marks and
// the fitted frame size. Sizes are written on the cfg channel, which is always ready, and
// are sampled when the first pixel of a frame arrives.
// At the first pixel of a frame the block runs a setup before it takes that word: it
// spots the word, latches the sizes and forms the size products, then runs up to three
// serial divisions, each giving a 28-bit quotient, for the fitted size and the column
// and row step sizes; the fitted-size division is skipped when the frame fits. Only
// then is the first word of a frame accepted.
// After setup one word is accepted per cycle while the output register is free, and a
// selected pixel appears on the output register in the cycle after its word is accepted.
// When the receiver stalls with a word held in the output register, input is held off
// until that word is taken. Reset clears all position counters and loads the default
// sizes of 1920x1080 source and 1280x720 limit; no memory needs clearing.
module aspect_fit_nearest_downscaler (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [afd_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [afd_pkg::DimW-1:0]      cfg_data_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [afd_pkg::PixW-1:0]      pixel_in_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [afd_pkg::PixW-1:0]      pixel_out_o,
  output logic                          row_end_o,
  output logic                          frame_end_o,
  output logic [afd_pkg::DimW-1:0]      frame_out_width_o,
  output logic [afd_pkg::DimW-1:0]      frame_out_height_o
);

  afd_pkg::cmd_t    cmd;
  afd_pkg::status_t status;

  assign cfg_ready_o = 1'b1;

  afd_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  afd_datapath u_dp (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cmd_i              (cmd),
    .status_o           (status),
    .cfg_valid_i        (cfg_valid_i),
    .cfg_index_i        (cfg_index_i),
    .cfg_data_i         (cfg_data_i),
    .pixel_in_i         (pixel_in_i),
    .out_valid_o        (out_valid_o),
    .out_ready_i        (out_ready_i),
    .pixel_out_o        (pixel_out_o),
    .row_end_o          (row_end_o),
    .frame_end_o        (frame_end_o),
    .frame_out_width_o  (frame_out_width_o),
    .frame_out_height_o (frame_out_height_o)
  );

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    status.div_busy |-> !in_ready_o)
    else $error("pixel accepted during frame setup");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |-> (!out_valid_o || out_ready_i))
    else $error("pixel accepted while output word is stalled");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && frame_end_o) |-> row_end_o)
    else $error("frame end without row end");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (frame_out_width_o != '0 && frame_out_height_o != '0))
    else $error("fitted frame size is zero");

endmodule

>>> design/afd_divider.sv
// Restoring serial divider, one quotient bit per cycle.
module afd_divider (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [afd_pkg::ProdW-1:0]   dividend_i,
  input  logic [afd_pkg::DimW-1:0]    divisor_i,
  output logic                        busy_o,
  output logic                        done_o,
  output logic [afd_pkg::ProdW-1:0]   quotient_o,
  output logic [afd_pkg::DimW-1:0]    remainder_o
);

  logic                        busy_q, busy_d;
  logic                        done_q, done_d;
  logic [afd_pkg::StepW-1:0]   cnt_q, cnt_d;
  logic [afd_pkg::ProdW-1:0]   quo_q, quo_d;
  logic [afd_pkg::DimW-1:0]    rem_q, rem_d;
  logic [afd_pkg::DimW-1:0]    div_q, div_d;
  logic [afd_pkg::DimW:0]      trial;
  logic                        fits;

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    quo_d  = quo_q;
    rem_d  = rem_q;
    div_d  = div_q;
    trial  = {rem_q, quo_q[afd_pkg::ProdW-1]};
    fits   = trial >= {1'b0, div_q};
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      quo_d  = dividend_i;
      rem_d  = '0;
      div_d  = divisor_i;
    end else if (busy_q) begin
      quo_d = {quo_q[afd_pkg::ProdW-2:0], fits};
      rem_d = fits ? afd_pkg::DimW'(trial - {1'b0, div_q}) : trial[afd_pkg::DimW-1:0];
      cnt_d = cnt_q + afd_pkg::StepW'(1);
      if (cnt_q == afd_pkg::StepW'(afd_pkg::ProdW - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    div_q <= div_d;
  end

  assign busy_o      = busy_q;
  assign done_o      = done_q;
  assign quotient_o  = quo_q;
  assign remainder_o = rem_q;

endmodule

>>> design/afd_datapath.sv
// Datapath: registers, frame fitting arithmetic, position tracking and output word.
module afd_datapath (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  afd_pkg::cmd_t                 cmd_i,
  output afd_pkg::status_t              status_o,
  input  logic                          cfg_valid_i,
  input  logic [afd_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [afd_pkg::DimW-1:0]      cfg_data_i,
  input  logic [afd_pkg::PixW-1:0]      pixel_in_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [afd_pkg::PixW-1:0]      pixel_out_o,
  output logic                          row_end_o,
  output logic                          frame_end_o,
  output logic [afd_pkg::DimW-1:0]      frame_out_width_o,
  output logic [afd_pkg::DimW-1:0]      frame_out_height_o
);

  localparam int unsigned DW = afd_pkg::DimW;
  localparam int unsigned CW = afd_pkg::CntW;

  logic [DW-1:0] cfg_sw_q, cfg_sh_q, cfg_mw_q, cfg_mh_q;
  logic [DW-1:0] w_q, h_q, mw_q, mh_q;
  logic [afd_pkg::ProdW-1:0] pa_q, pb_q;
  logic [DW-1:0] fw_q, fw_d, fh_q, fh_d;
  logic [DW-1:0] qw_q, rw_q, qh_q, rh_q;
  logic [CW-1:0] src_col_q, src_col_d, src_row_q, src_row_d;
  logic [CW-1:0] dst_col_q, dst_col_d;
  logic [DW-1:0] dst_row_q, dst_row_d;
  logic [DW-1:0] colq_q, colq_d, rowq_q, rowq_d;
  logic [DW-1:0] colr_q, colr_d, rowr_q, rowr_d;
  logic          out_valid_q, out_valid_d;
  logic [afd_pkg::PixW-1:0] pix_q;
  logic          re_q, re_d, fe_q, fe_d;
  logic [DW-1:0] ofw_q, ofh_q;

  logic          limw, need_div, emit, out_free;
  logic [afd_pkg::ProdW-1:0] div_dividend;
  logic [DW-1:0] div_divisor, quot, div_rem;
  logic [afd_pkg::ProdW-1:0] quo_full;
  logic          div_busy, div_done;
  logic [DW:0]   col_sum, row_sum;
  logic [DW-1:0] dst_col_inc;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_sw_q <= DW'(1920);
      cfg_sh_q <= DW'(1080);
      cfg_mw_q <= DW'(1280);
      cfg_mh_q <= DW'(720);
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        afd_pkg::RegSrcW: cfg_sw_q <= cfg_data_i;
        afd_pkg::RegSrcH: cfg_sh_q <= cfg_data_i;
        afd_pkg::RegMaxW: cfg_mw_q <= cfg_data_i;
        afd_pkg::RegMaxH: cfg_mh_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign limw     = pa_q > pb_q;
  assign need_div = (w_q > mw_q) || (h_q > mh_q);

  always_comb begin
    unique case (cmd_i.div_sel)
      afd_pkg::DIV_COL: begin
        div_dividend = afd_pkg::ProdW'(w_q);
        div_divisor  = fw_q;
      end
      afd_pkg::DIV_ROW: begin
        div_dividend = afd_pkg::ProdW'(h_q);
        div_divisor  = fh_q;
      end
      default: begin
        div_dividend = limw ? pb_q : pa_q;
        div_divisor  = limw ? w_q : h_q;
      end
    endcase
  end

  afd_divider u_div (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (cmd_i.div_start),
    .dividend_i  (div_dividend),
    .divisor_i   (div_divisor),
    .busy_o      (div_busy),
    .done_o      (div_done),
    .quotient_o  (quo_full),
    .remainder_o (div_rem)
  );

  assign quot = (quo_full[DW-1:0] == '0) ? DW'(1) : quo_full[DW-1:0];

  always_comb begin
    fw_d = fw_q;
    fh_d = fh_q;
    if (cmd_i.fit) begin
      if (!need_div) begin
        fw_d = w_q;
        fh_d = h_q;
      end else if (limw) begin
        fw_d = mw_q;
      end else begin
        fh_d = mh_q;
      end
    end else if (cmd_i.store_fit) begin
      if (limw) begin
        fh_d = quot;
      end else begin
        fw_d = quot;
      end
    end
  end

  assign out_free = !out_valid_q || out_ready_i;
  assign emit = (dst_row_q < fh_q) && (DW'(src_row_q) == rowq_q) &&
                (DW'(src_col_q) == colq_q);
  assign dst_col_inc = DW'(dst_col_q) + DW'(1);
  assign col_sum = {1'b0, colr_q} + {1'b0, rw_q};
  assign row_sum = {1'b0, rowr_q} + {1'b0, rh_q};

  always_comb begin
    src_col_d   = src_col_q;
    src_row_d   = src_row_q;
    dst_col_d   = dst_col_q;
    dst_row_d   = dst_row_q;
    colq_d      = colq_q;
    colr_d      = colr_q;
    rowq_d      = rowq_q;
    rowr_d      = rowr_q;
    re_d        = 1'b0;
    fe_d        = 1'b0;
    out_valid_d = out_valid_q && !out_ready_i;
    if (cmd_i.latch) begin
      dst_col_d = '0;
      dst_row_d = '0;
      colq_d    = '0;
      colr_d    = '0;
      rowq_d    = '0;
      rowr_d    = '0;
    end else if (cmd_i.accept) begin
      if (emit) begin
        out_valid_d = 1'b1;
        if (dst_col_inc == fw_q) begin
          dst_col_d = '0;
          colq_d    = '0;
          colr_d    = '0;
          re_d      = 1'b1;
          dst_row_d = dst_row_q + DW'(1);
          fe_d      = (dst_row_q + DW'(1)) >= fh_q;
          if (row_sum >= {1'b0, fh_q}) begin
            rowr_d = DW'(row_sum - {1'b0, fh_q});
            rowq_d = rowq_q + qh_q + DW'(1);
          end else begin
            rowr_d = row_sum[DW-1:0];
            rowq_d = rowq_q + qh_q;
          end
        end else begin
          dst_col_d = dst_col_inc[CW-1:0];
          if (col_sum >= {1'b0, fw_q}) begin
            colr_d = DW'(col_sum - {1'b0, fw_q});
            colq_d = colq_q + qw_q + DW'(1);
          end else begin
            colr_d = col_sum[DW-1:0];
            colq_d = colq_q + qw_q;
          end
        end
      end
      if ((DW'(src_col_q) + DW'(1)) == w_q) begin
        src_col_d = '0;
        if ((DW'(src_row_q) + DW'(1)) == h_q) begin
          src_row_d = '0;
        end else begin
          src_row_d = src_row_q + CW'(1);
        end
      end else begin
        src_col_d = src_col_q + CW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      src_col_q   <= '0;
      src_row_q   <= '0;
      dst_col_q   <= '0;
      dst_row_q   <= '0;
      colq_q      <= '0;
      colr_q      <= '0;
      rowq_q      <= '0;
      rowr_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      src_col_q   <= src_col_d;
      src_row_q   <= src_row_d;
      dst_col_q   <= dst_col_d;
      dst_row_q   <= dst_row_d;
      colq_q      <= colq_d;
      colr_q      <= colr_d;
      rowq_q      <= rowq_d;
      rowr_q      <= rowr_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    fw_q <= fw_d;
    fh_q <= fh_d;
    if (cmd_i.latch) begin
      w_q  <= afd_pkg::clamp_dim(cfg_sw_q);
      h_q  <= afd_pkg::clamp_dim(cfg_sh_q);
      mw_q <= afd_pkg::clamp_dim(cfg_mw_q);
      mh_q <= afd_pkg::clamp_dim(cfg_mh_q);
    end
    if (cmd_i.mul) begin
      pa_q <= afd_pkg::ProdW'(w_q) * afd_pkg::ProdW'(mh_q);
      pb_q <= afd_pkg::ProdW'(h_q) * afd_pkg::ProdW'(mw_q);
    end
    if (cmd_i.store_col) begin
      qw_q <= quo_full[DW-1:0];
      rw_q <= div_rem;
    end
    if (cmd_i.store_row) begin
      qh_q <= quo_full[DW-1:0];
      rh_q <= div_rem;
    end
    if (cmd_i.accept && emit) begin
      pix_q <= pixel_in_i;
      re_q  <= re_d;
      fe_q  <= fe_d;
      ofw_q <= fw_q;
      ofh_q <= fh_q;
    end
  end

  assign status_o.frame_start = (src_col_q == '0) && (src_row_q == '0);
  assign status_o.out_free    = out_free;
  assign status_o.need_div    = need_div;
  assign status_o.div_done    = div_done;
  assign status_o.div_busy    = div_busy;

  assign out_valid_o        = out_valid_q;
  assign pixel_out_o        = pix_q;
  assign row_end_o          = re_q;
  assign frame_end_o        = fe_q;
  assign frame_out_width_o  = ofw_q;
  assign frame_out_height_o = ofh_q;

endmodule

>>> design/afd_ctrl.sv
// Controller state machine: frame setup sequence and pixel acceptance.
module afd_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  afd_pkg::status_t  status_i,
  output afd_pkg::cmd_t     cmd_o
);

  afd_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= afd_pkg::ST_RUN;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    cmd_o.div_sel = afd_pkg::DIV_FIT;
    in_ready_o = 1'b0;
    unique case (state_q)
      afd_pkg::ST_RUN: begin
        in_ready_o = status_i.out_free && !status_i.frame_start;
        if (in_valid_i && status_i.frame_start) begin
          state_d = afd_pkg::ST_LATCH;
        end
      end
      afd_pkg::ST_LATCH: begin
        cmd_o.latch = 1'b1;
        state_d     = afd_pkg::ST_MUL;
      end
      afd_pkg::ST_MUL: begin
        cmd_o.mul = 1'b1;
        state_d   = afd_pkg::ST_FIT;
      end
      afd_pkg::ST_FIT: begin
        cmd_o.fit       = 1'b1;
        cmd_o.div_start = status_i.need_div;
        state_d = status_i.need_div ? afd_pkg::ST_FIT_WAIT : afd_pkg::ST_COL;
      end
      afd_pkg::ST_FIT_WAIT: begin
        if (status_i.div_done) begin
          cmd_o.store_fit = 1'b1;
          state_d         = afd_pkg::ST_COL;
        end
      end
      afd_pkg::ST_COL: begin
        cmd_o.div_start = 1'b1;
        cmd_o.div_sel   = afd_pkg::DIV_COL;
        state_d         = afd_pkg::ST_COL_WAIT;
      end
      afd_pkg::ST_COL_WAIT: begin
        if (status_i.div_done) begin
          cmd_o.store_col = 1'b1;
          state_d         = afd_pkg::ST_ROW;
        end
      end
      afd_pkg::ST_ROW: begin
        cmd_o.div_start = 1'b1;
        cmd_o.div_sel   = afd_pkg::DIV_ROW;
        state_d         = afd_pkg::ST_ROW_WAIT;
      end
      afd_pkg::ST_ROW_WAIT: begin
        if (status_i.div_done) begin
          cmd_o.store_row = 1'b1;
          state_d         = afd_pkg::ST_FIRST;
        end
      end
      afd_pkg::ST_FIRST: begin
        in_ready_o = status_i.out_free;
        if (in_valid_i && status_i.out_free) begin
          state_d = afd_pkg::ST_RUN;
        end
      end
      default: state_d = afd_pkg::ST_RUN;
    endcase
    cmd_o.accept = in_valid_i && in_ready_o;
  end

endmodule

>>> dv/tb_aspect_fit_nearest_downscaler.sv
// Testbench for the aspect-fit nearest-neighbour downscaler with a scoreboard of expected pixels.
module tb_aspect_fit_nearest_downscaler;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic [afd_pkg::PixW-1:0] pix;
    logic                     row_end;
    logic                     frame_end;
    logic [afd_pkg::DimW-1:0] fit_w;
    logic [afd_pkg::DimW-1:0] fit_h;
  } scaled_pix_t;

  class downscale_scoreboard;
    logic [afd_pkg::DimW-1:0] src_w_reg, src_h_reg, lim_w_reg, lim_h_reg;
    longint unsigned col, row, out_col, out_row, frame_w, frame_h, fit_w, fit_h;
    scaled_pix_t     pending_pix[$];
    int              mismatches;
    int              matched;

    function longint unsigned clip(logic [afd_pkg::DimW-1:0] v);
      if (v == '0) return 1;
      if (v > afd_pkg::DimW'(afd_pkg::MaxDim)) return afd_pkg::MaxDim;
      return v;
    endfunction

    function void latch_frame();
      longint unsigned w, h, mw, mh;
      w = clip(src_w_reg);
      h = clip(src_h_reg);
      mw = clip(lim_w_reg);
      mh = clip(lim_h_reg);
      fit_w = w;
      fit_h = h;
      if (w > mw || h > mh) begin
        if (w * mh > h * mw) begin
          fit_w = mw;
          fit_h = h * mw / w;
        end else begin
          fit_h = mh;
          fit_w = w * mh / h;
        end
        if (fit_w < 1) fit_w = 1;
        if (fit_h < 1) fit_h = 1;
      end
      frame_w = w;
      frame_h = h;
    endfunction

    function new();
      src_w_reg = 1920;
      src_h_reg = 1080;
      lim_w_reg = 1280;
      lim_h_reg = 720;
      col = 0; row = 0; out_col = 0; out_row = 0;
      mismatches = 0;
      matched = 0;
      latch_frame();
    endfunction

    function void write_reg(logic [afd_pkg::CfgIdxW-1:0] idx, logic [afd_pkg::DimW-1:0] data);
      case (idx)
        afd_pkg::RegSrcW: src_w_reg = data;
        afd_pkg::RegSrcH: src_h_reg = data;
        afd_pkg::RegMaxW: lim_w_reg = data;
        afd_pkg::RegMaxH: lim_h_reg = data;
        default: ;
      endcase
    endfunction

    function void note_pixel(logic [afd_pkg::PixW-1:0] p);
      scaled_pix_t e;
      longint unsigned want_row, want_col;
      if (col == 0 && row == 0) begin
        latch_frame();
        out_col = 0;
        out_row = 0;
      end
      want_row = out_row * frame_h / fit_h;
      want_col = out_col * frame_w / fit_w;
      if (out_row < fit_h && out_col < fit_w && row == want_row && col == want_col) begin
        e.pix = p;
        e.row_end = 1'b0;
        e.frame_end = 1'b0;
        out_col++;
        if (out_col >= fit_w) begin
          out_col = 0;
          e.row_end = 1'b1;
          out_row++;
          if (out_row >= fit_h) e.frame_end = 1'b1;
        end
        e.fit_w = afd_pkg::DimW'(fit_w);
        e.fit_h = afd_pkg::DimW'(fit_h);
        pending_pix.push_back(e);
      end
      col++;
      if (col >= frame_w) begin
        col = 0;
        row++;
        if (row >= frame_h) begin
          row = 0;
          out_col = 0;
          out_row = 0;
        end
      end
    endfunction

    function void check_result(scaled_pix_t got);
      scaled_pix_t e;
      if (pending_pix.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("Unexpected word: pix %h row_end %b frame_end %b size %0dx%0d",
                   got.pix, got.row_end, got.frame_end, got.fit_w, got.fit_h);
        return;
      end
      e = pending_pix.pop_front();
      if (e.pix !== got.pix || e.row_end !== got.row_end || e.frame_end !== got.frame_end ||
          e.fit_w !== got.fit_w || e.fit_h !== got.fit_h) begin
        mismatches++;
        if (mismatches <= 10)
          $display({"Mismatch: expected pix %h re %b fe %b %0dx%0d,",
                    " got pix %h re %b fe %b %0dx%0d"},
                   e.pix, e.row_end, e.frame_end, e.fit_w, e.fit_h,
                   got.pix, got.row_end, got.frame_end, got.fit_w, got.fit_h);
      end else begin
        matched++;
      end
    endfunction
  endclass

  localparam int unsigned WatchdogLimit = 20000;

  logic                        clk_i = 1'b0;
  logic                        rst_ni = 1'b0;
  logic                        cfg_valid_i = 1'b0;
  logic                        cfg_ready_o;
  logic [afd_pkg::CfgIdxW-1:0] cfg_index_i = '0;
  logic [afd_pkg::DimW-1:0]    cfg_data_i = '0;
  logic                        in_valid_i = 1'b0;
  logic                        in_ready_o;
  logic [afd_pkg::PixW-1:0]    pixel_in_i = '0;
  logic                        out_valid_o;
  logic                        out_ready_i = 1'b0;
  logic [afd_pkg::PixW-1:0]    pixel_out_o;
  logic                        row_end_o;
  logic                        frame_end_o;
  logic [afd_pkg::DimW-1:0]    frame_out_width_o;
  logic [afd_pkg::DimW-1:0]    frame_out_height_o;

  downscale_scoreboard sb = new();
  int sender_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_request = 0;
  int quiet_cycles = 0;
  int pixels_sent = 0;
  int phases_run = 0;

  aspect_fit_nearest_downscaler DUT (.*);

  always #2 clk_i = ~clk_i;

  always @(negedge clk_i) begin
    if (hold_request > 0) begin
      out_ready_i <= 1'b0;
      hold_request <= hold_request - 1;
    end else begin
      out_ready_i <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk_i) begin
    scaled_pix_t got;
    if (out_valid_o && out_ready_i) begin
      got.pix = pixel_out_o;
      got.row_end = row_end_o;
      got.frame_end = frame_end_o;
      got.fit_w = frame_out_width_o;
      got.fit_h = frame_out_height_o;
      sb.check_result(got);
    end
    if (in_valid_i && in_ready_o) sb.note_pixel(pixel_in_i);
    if ((out_valid_o && out_ready_i) || (in_valid_i && in_ready_o) ||
        (cfg_valid_i && cfg_ready_o)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles + 1 >= WatchdogLimit) begin
      $display("Watchdog expired with %0d words outstanding", sb.pending_pix.size());
      $display("*** FAILED ***");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic cfg_write(logic [afd_pkg::CfgIdxW-1:0] idx, logic [afd_pkg::DimW-1:0] data);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    sb.write_reg(idx, data);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic set_sizes(int w, int h, int mw, int mh);
    cfg_write(afd_pkg::RegSrcW, afd_pkg::DimW'(w));
    cfg_write(afd_pkg::RegSrcH, afd_pkg::DimW'(h));
    cfg_write(afd_pkg::RegMaxW, afd_pkg::DimW'(mw));
    cfg_write(afd_pkg::RegMaxH, afd_pkg::DimW'(mh));
  endtask

  // Called at a falling edge; returns at the falling edge after the word is taken.
  task automatic send_pixel(logic [afd_pkg::PixW-1:0] p);
    if ($urandom_range(99) < sender_idle_pct) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(3, 1)) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    pixel_in_i <= p;
    do @(posedge clk_i); while (!in_ready_o);
    pixels_sent++;
    @(negedge clk_i);
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (sb.pending_pix.size() != 0) @(negedge clk_i);
    repeat (300) @(negedge clk_i);
  endtask

  task automatic send_random(int n);
    @(negedge clk_i);
    repeat (n) send_pixel($urandom());
    drain();
  endtask

  initial begin
    int budget;
    int mode;
    repeat (9) @(negedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(negedge clk_i);

    // A frame that fits passes straight through.
    set_sizes(4, 3, 8, 8);
    @(negedge clk_i);
    send_pixel('0);
    send_pixel('1);
    send_pixel(32'h5555_5555);
    send_pixel(32'hAAAA_AAAA);
    repeat (8) send_pixel($urandom());
    drain();
    // Width limits the fit, then height limits it.
    set_sizes(6, 2, 3, 3);
    send_random(12);
    set_sizes(2, 6, 3, 3);
    send_random(12);
    // Zero sizes act as one, and writes to unknown indexes are dropped.
    set_sizes(0, 0, 0, 0);
    cfg_write(afd_pkg::CfgIdxW'(4), '1);
    cfg_write('1, afd_pkg::DimW'($urandom()));
    send_random(3);

    // Oversized limits clamp and the frame passes whole, then it is squeezed to one pixel.
    set_sizes(12, 2, 16383, 9000);
    send_random(24);
    set_sizes(12, 1, 1, 1);
    send_random(12);

    budget = 1180;
    while (budget > 0) begin
      int n;
      mode = phases_run % 4;
      sender_idle_pct = (mode == 1 || mode == 3) ? ((mode == 1) ? 77 : 14) : 0;
      recv_stall_pct = (mode == 2 || mode == 3) ? ((mode == 2) ? 77 : 14) : 0;
      set_sizes($urandom_range(12, 1), $urandom_range(12, 1),
                ($urandom_range(9) == 0) ? $urandom_range(16383, 8000) : $urandom_range(12, 0),
                ($urandom_range(9) == 0) ? $urandom_range(16383, 8000) : $urandom_range(12, 0));
      if ($urandom_range(3) == 0)
        cfg_write(afd_pkg::CfgIdxW'($urandom_range(15, 4)), afd_pkg::DimW'($urandom()));
      n = $urandom_range(120, 30);
      if (phases_run == 5) begin
        sender_idle_pct = 0;
        recv_stall_pct = 0;
        hold_request = 500;
      end
      send_random(n);
      budget -= n;
      phases_run++;
    end

    $display("Fed %0d source pixels over %0d random size settings plus directed cases;",
             pixels_sent, phases_run);
    $display("%0d output words matched, including pass-through, clamped and 1x1 fits.",
             sb.matched);
    if (sb.mismatches == 0 && sb.pending_pix.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("%0d mismatches, %0d words never seen", sb.mismatches, sb.pending_pix.size());
      $display("*** FAILED ***");
    end
    $finish;
  end
endmodule
